// ----- design/jdit_pkg.sv -----
// Shared constants for the Jacobian determinant and inverse-transpose unit.
package jdit_pkg;

    localparam int TAG_W = 8;
    localparam int DIM_W = 2;
    localparam int NUM_ENTRIES = 9;

    // Active matrix size codes; any other code acts as size one.
    localparam logic [DIM_W-1:0] DIM_ZERO  = 2'd0;
    localparam logic [DIM_W-1:0] DIM_ONE   = 2'd1;
    localparam logic [DIM_W-1:0] DIM_TWO   = 2'd2;
    localparam logic [DIM_W-1:0] DIM_THREE = 2'd3;
    localparam logic [DIM_W-1:0] DIM_RESET = DIM_THREE;

endpackage

// ----- design/jdit_if.sv -----
// Valid/ready channel interfaces for the matrix items and the result items.
interface jdit_in_if #(
    parameter int DATA_WIDTH = 32
);
    import jdit_pkg::*;

    logic                         valid;
    logic                         ready;
    logic [TAG_W-1:0]             point_tag;
    logic signed [DATA_WIDTH-1:0] a00;
    logic signed [DATA_WIDTH-1:0] a01;
    logic signed [DATA_WIDTH-1:0] a02;
    logic signed [DATA_WIDTH-1:0] a10;
    logic signed [DATA_WIDTH-1:0] a11;
    logic signed [DATA_WIDTH-1:0] a12;
    logic signed [DATA_WIDTH-1:0] a20;
    logic signed [DATA_WIDTH-1:0] a21;
    logic signed [DATA_WIDTH-1:0] a22;

    modport source (
        output valid, point_tag, a00, a01, a02, a10, a11, a12, a20, a21, a22,
        input  ready
    );
    modport sink (
        input  valid, point_tag, a00, a01, a02, a10, a11, a12, a20, a21, a22,
        output ready
    );
endinterface

interface jdit_out_if #(
    parameter int DATA_WIDTH = 32
);
    import jdit_pkg::*;

    logic                         valid;
    logic                         ready;
    logic [TAG_W-1:0]             tag_out;
    logic signed [DATA_WIDTH-1:0] determinant;
    logic signed [DATA_WIDTH-1:0] t00;
    logic signed [DATA_WIDTH-1:0] t01;
    logic signed [DATA_WIDTH-1:0] t02;
    logic signed [DATA_WIDTH-1:0] t10;
    logic signed [DATA_WIDTH-1:0] t11;
    logic signed [DATA_WIDTH-1:0] t12;
    logic signed [DATA_WIDTH-1:0] t20;
    logic signed [DATA_WIDTH-1:0] t21;
    logic signed [DATA_WIDTH-1:0] t22;
    logic                         singular;

    modport source (
        output valid, tag_out, determinant, t00, t01, t02, t10, t11, t12, t20, t21, t22,
               singular,
        input  ready
    );
    modport sink (
        input  valid, tag_out, determinant, t00, t01, t02, t10, t11, t12, t20, t21, t22,
               singular,
        output ready
    );
endinterface

// ----- design/jdit_cofactor.sv -----
// Two pipeline stages: pair products, then signed cofactors for the active size.
module jdit_cofactor #(
    parameter int W = 32
) (
    input  logic                          i_clk,
    input  logic [1:0]                    i_en,
    input  logic [jdit_pkg::DIM_W-1:0]    i_dim,
    input  logic signed [W-1:0]           i_a [jdit_pkg::NUM_ENTRIES],
    output logic [jdit_pkg::DIM_W-1:0]    o_dim,
    output logic signed [W-1:0]           o_a0 [3],
    output logic signed [2*W:0]           o_cof3 [jdit_pkg::NUM_ENTRIES],
    output logic signed [2*W:0]           o_cof [jdit_pkg::NUM_ENTRIES]
);
    import jdit_pkg::*;

    localparam int PW = 2 * W;
    localparam int CW = 2 * W + 1;

    logic signed [PW-1:0] r_p [NUM_ENTRIES];
    logic signed [PW-1:0] r_q [NUM_ENTRIES];
    logic signed [W-1:0]  r_a [NUM_ENTRIES];
    logic [DIM_W-1:0]     r_dim;

    logic signed [CW-1:0] n_cof3 [NUM_ENTRIES];
    logic signed [CW-1:0] n_cof [NUM_ENTRIES];

    logic [DIM_W-1:0]     r_b_dim;
    logic signed [W-1:0]  r_b_a0 [3];
    logic signed [CW-1:0] r_b_cof3 [NUM_ENTRIES];
    logic signed [CW-1:0] r_b_cof [NUM_ENTRIES];

    // Stage A: the two cross products of every 2x2 minor.
    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_a   <= i_a;
            r_dim <= i_dim;
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    r_p[i*3+j] <= PW'(i_a[((i+1)%3)*3 + (j+1)%3])
                                * PW'(i_a[((i+2)%3)*3 + (j+2)%3]);
                    r_q[i*3+j] <= PW'(i_a[((i+1)%3)*3 + (j+2)%3])
                                * PW'(i_a[((i+2)%3)*3 + (j+1)%3]);
                end
            end
        end
    end

    // Stage B: full 3x3 cofactors, and the cofactor set of the active size.
    always_comb begin
        for (int k = 0; k < NUM_ENTRIES; k++) begin
            n_cof3[k] = CW'(r_p[k]) - CW'(r_q[k]);
            n_cof[k]  = '0;
        end
        unique case (r_dim)
            DIM_THREE: begin
                n_cof = n_cof3;
            end
            DIM_TWO: begin
                n_cof[0] = CW'(r_a[4]);
                n_cof[1] = -CW'(r_a[3]);
                n_cof[3] = -CW'(r_a[1]);
                n_cof[4] = CW'(r_a[0]);
            end
            default: begin
                n_cof[0] = CW'(1);
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r_b_dim  <= r_dim;
            r_b_a0   <= r_a[0:2];
            r_b_cof3 <= n_cof3;
            r_b_cof  <= n_cof;
        end
    end

    assign o_dim  = r_b_dim;
    assign o_a0   = r_b_a0;
    assign o_cof3 = r_b_cof3;
    assign o_cof  = r_b_cof;

endmodule

// ----- design/jdit_det.sv -----
// Four pipeline stages: determinant by first-row expansion, then magnitudes.
module jdit_det #(
    parameter int W = 32,
    parameter int F = 16
) (
    input  logic                          i_clk,
    input  logic [3:0]                    i_en,
    input  logic [jdit_pkg::DIM_W-1:0]    i_dim,
    input  logic signed [W-1:0]           i_a0 [3],
    input  logic signed [2*W:0]           i_cof3 [jdit_pkg::NUM_ENTRIES],
    input  logic signed [2*W:0]           i_cof [jdit_pkg::NUM_ENTRIES],
    output logic [3*W-1:0]                o_den,
    output logic [3*W-1:0]                o_det_shr,
    output logic                          o_det_neg,
    output logic                          o_singular,
    output logic [2*W+2*F-1:0]            o_num [jdit_pkg::NUM_ENTRIES],
    output logic [jdit_pkg::NUM_ENTRIES-1:0] o_num_neg
);
    import jdit_pkg::*;

    localparam int CW = 2 * W + 1;
    localparam int DW = 3 * W + 1;
    localparam int MW = 3 * W;
    localparam int NW = 2 * W + 2 * F;

    // Stage C
    logic signed [CW-1:0] r_c_lo [3];
    logic signed [CW-1:0] r_c_hi [3];
    logic signed [CW-1:0] r_c_cof [NUM_ENTRIES];
    logic signed [CW-1:0] r_c_det2;
    logic signed [W-1:0]  r_c_a00;
    logic [DIM_W-1:0]     r_c_dim;
    // Stage D
    logic signed [DW-1:0] r_d_term [3];
    logic signed [CW-1:0] r_d_cof [NUM_ENTRIES];
    logic signed [CW-1:0] r_d_det2;
    logic signed [W-1:0]  r_d_a00;
    logic [DIM_W-1:0]     r_d_dim;
    // Stage E
    logic signed [DW-1:0] n_det;
    logic signed [DW-1:0] r_e_det;
    logic signed [CW-1:0] r_e_cof [NUM_ENTRIES];
    logic [DIM_W-1:0]     r_e_dim;
    // Stage F
    logic [DW-1:0]        n_det_abs;
    logic [MW-1:0]        n_shr;
    logic [CW-1:0]        n_cabs [NUM_ENTRIES];
    logic [NW-1:0]        n_num [NUM_ENTRIES];
    logic [MW-1:0]        r_f_den;
    logic [MW-1:0]        r_f_shr;
    logic                 r_f_neg;
    logic                 r_f_sing;
    logic [NW-1:0]        r_f_num [NUM_ENTRIES];
    logic [NUM_ENTRIES-1:0] r_f_num_neg;

    // Stage C: split each first-row cofactor in two halves to keep the multipliers narrow.
    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            for (int j = 0; j < 3; j++) begin
                r_c_lo[j] <= CW'(i_a0[j]) * CW'($signed({1'b0, i_cof3[j][W-1:0]}));
                r_c_hi[j] <= CW'(i_a0[j]) * CW'($signed(i_cof3[j][CW-1:W]));
            end
            r_c_cof  <= i_cof;
            r_c_det2 <= i_cof3[8];
            r_c_a00  <= i_a0[0];
            r_c_dim  <= i_dim;
        end
    end

    // Stage D: recombine the halves.
    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            for (int j = 0; j < 3; j++) begin
                r_d_term[j] <= (DW'(r_c_hi[j]) <<< W) + DW'(r_c_lo[j]);
            end
            r_d_cof  <= r_c_cof;
            r_d_det2 <= r_c_det2;
            r_d_a00  <= r_c_a00;
            r_d_dim  <= r_c_dim;
        end
    end

    // Stage E: pick the determinant of the active size.
    always_comb begin
        unique case (r_d_dim)
            DIM_THREE: n_det = r_d_term[0] + r_d_term[1] + r_d_term[2];
            DIM_TWO:   n_det = DW'(r_d_det2);
            default:   n_det = DW'(r_d_a00);
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en[2]) begin
            r_e_det <= n_det;
            r_e_cof <= r_d_cof;
            r_e_dim <= r_d_dim;
        end
    end

    // Stage F: sign and magnitude; drop the extra fraction bits of the determinant.
    always_comb begin
        n_det_abs = r_e_det[DW-1] ? (DW'(0) - r_e_det) : r_e_det;
        unique case (r_e_dim)
            DIM_THREE: n_shr = n_det_abs[MW-1:0] >> (2 * F);
            DIM_TWO:   n_shr = n_det_abs[MW-1:0] >> F;
            default:   n_shr = n_det_abs[MW-1:0];
        endcase
        for (int k = 0; k < NUM_ENTRIES; k++) begin
            n_cabs[k] = r_e_cof[k][CW-1] ? (CW'(0) - r_e_cof[k]) : r_e_cof[k];
            n_num[k]  = {n_cabs[k][CW-2:0], {(2 * F){1'b0}}};
        end
    end

    // Quotient sign: cofactor sign against determinant sign.
    always_ff @(posedge i_clk) begin
        if (i_en[3]) begin
            r_f_den  <= n_det_abs[MW-1:0];
            r_f_shr  <= n_shr;
            r_f_neg  <= r_e_det[DW-1];
            r_f_sing <= (r_e_det == '0);
            r_f_num  <= n_num;
            for (int k = 0; k < NUM_ENTRIES; k++) begin
                r_f_num_neg[k] <= r_e_cof[k][CW-1] ^ r_e_det[DW-1];
            end
        end
    end

    assign o_den      = r_f_den;
    assign o_det_shr  = r_f_shr;
    assign o_det_neg  = r_f_neg;
    assign o_singular = r_f_sing;
    assign o_num      = r_f_num;
    assign o_num_neg  = r_f_num_neg;

endmodule

// ----- design/jdit_div.sv -----
// Nine-lane restoring divider, one quotient bit per stage, sharing one divisor.
module jdit_div #(
    parameter int W  = 32,
    parameter int NW = 96,
    parameter int MW = 96
) (
    input  logic                             i_clk,
    input  logic [W:0]                       i_en,
    input  logic [NW-1:0]                    i_num [jdit_pkg::NUM_ENTRIES],
    input  logic [jdit_pkg::NUM_ENTRIES-1:0] i_num_neg,
    input  logic [MW-1:0]                    i_den,
    output logic [W-1:0]                     o_quo [jdit_pkg::NUM_ENTRIES],
    output logic [jdit_pkg::NUM_ENTRIES-1:0] o_ovf,
    output logic [jdit_pkg::NUM_ENTRIES-1:0] o_neg
);
    import jdit_pkg::*;

    localparam int XW = ((NW > MW + W) ? NW : MW + W) + 1;

    logic [XW-1:0]          r_rem [W][NUM_ENTRIES];
    logic [MW-1:0]          r_den [W];
    logic [W-1:0]           r_q   [W+1][NUM_ENTRIES];
    logic [NUM_ENTRIES-1:0] r_ovf [W+1];
    logic [NUM_ENTRIES-1:0] r_neg [W+1];

    logic [XW-1:0]          w_sub [1:W];
    logic [NUM_ENTRIES-1:0] w_ge  [1:W];

    always_comb begin
        for (int s = 1; s <= W; s++) begin
            w_sub[s] = XW'(r_den[s-1]) << (W - s);
            for (int l = 0; l < NUM_ENTRIES; l++) begin
                w_ge[s][l] = (r_rem[s-1][l] >= w_sub[s]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        // Entry: flag quotients that cannot fit W bits.
        if (i_en[0]) begin
            r_den[0] <= i_den;
            r_neg[0] <= i_num_neg;
            for (int l = 0; l < NUM_ENTRIES; l++) begin
                r_rem[0][l] <= XW'(i_num[l]);
                r_ovf[0][l] <= (XW'(i_num[l]) >= (XW'(i_den) << W));
                r_q[0][l]   <= '0;
            end
        end
        for (int s = 1; s <= W; s++) begin
            if (i_en[s]) begin
                r_ovf[s] <= r_ovf[s-1];
                r_neg[s] <= r_neg[s-1];
                for (int l = 0; l < NUM_ENTRIES; l++) begin
                    r_q[s][l] <= r_q[s-1][l] | (W'(w_ge[s][l]) << (W - s));
                end
            end
        end
        for (int s = 1; s < W; s++) begin
            if (i_en[s]) begin
                r_den[s] <= r_den[s-1];
                for (int l = 0; l < NUM_ENTRIES; l++) begin
                    r_rem[s][l] <= w_ge[s][l] ? (r_rem[s-1][l] - w_sub[s]) : r_rem[s-1][l];
                end
            end
        end
    end

    assign o_quo = r_q[W];
    assign o_ovf = r_ovf[W];
    assign o_neg = r_neg[W];

endmodule

// ----- design/jacobian_det_inverse_transpose_unit.sv -----
// Top level: pipelined 3x3 Jacobian determinant and transposed inverse.
//
// Usage
//   i_in carries one matrix item (point tag and nine signed Q16.16 entries) per
//   valid/ready handshake; o_out returns one result item per input item, in
//   order: the echoed tag, the determinant, the transposed inverse t00..t22
//   (cofactor over determinant) and a singular flag. Results are truncated
//   toward zero and saturated to DATA_WIDTH bits. Entries outside the active
//   size read as zero; a zero determinant zeroes every output and sets singular.
//   i_cfg_wr_en/i_cfg_wr_data set the active size (1, 2 or 3; 0 acts as 1);
//   write it only while no item is in flight.
// Timing
//   DATA_WIDTH + 8 register stages: two for cofactors, four for the determinant,
//   DATA_WIDTH + 1 for the divider (an entry stage, then one quotient bit per
//   stage) and the output register. With no stall one item is taken every cycle.
// Reset and stall
//   Reset clears every stage valid bit and sets the size to 3. Each stage holds
//   while the one after it is full and stalled, so bubbles close up and the
//   input stays ready until every stage holds an item.
module jacobian_det_inverse_transpose_unit #(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_wr_en,
    input  logic [jdit_pkg::DIM_W-1:0] i_cfg_wr_data,
    jdit_in_if.sink                    i_in,
    jdit_out_if.source                 o_out
);
    import jdit_pkg::*;

    localparam int W  = DATA_WIDTH;
    localparam int F  = FRAC_BITS;
    localparam int CW = 2 * W + 1;
    localparam int MW = 3 * W;
    localparam int NW = 2 * W + 2 * F;
    // Stage map: 0-1 cofactors, 2-5 determinant, 6..6+W divider, last is output.
    localparam int DIV0 = 6;
    localparam int NS   = W + 8;

    localparam logic [MW-1:0] DET_LIM = MW'(1) << (W - 1);
    localparam logic [W-1:0]  Q_LIM   = W'(1) << (W - 1);
    localparam logic [W-1:0]  SAT_MAX = {1'b0, {(W - 1){1'b1}}};
    localparam logic [W-1:0]  SAT_MIN = {1'b1, {(W - 1){1'b0}}};

    logic [DIM_W-1:0]       r_dim;
    logic [NS-1:0]          r_vld;
    logic [NS:0]            w_en;
    logic [TAG_W-1:0]       r_tag [NS];

    logic signed [W-1:0]    w_a [NUM_ENTRIES];
    logic [DIM_W-1:0]       w_cf_dim;
    logic signed [W-1:0]    w_cf_a0 [3];
    logic signed [CW-1:0]   w_cf_cof3 [NUM_ENTRIES];
    logic signed [CW-1:0]   w_cf_cof [NUM_ENTRIES];

    logic [MW-1:0]          w_den;
    logic [MW-1:0]          w_det_shr;
    logic                   w_det_neg;
    logic                   w_sing;
    logic [NW-1:0]          w_num [NUM_ENTRIES];
    logic [NUM_ENTRIES-1:0] w_num_neg;

    logic [W-1:0]           w_quo [NUM_ENTRIES];
    logic [NUM_ENTRIES-1:0] w_ovf;
    logic [NUM_ENTRIES-1:0] w_neg;

    logic [W-1:0]           n_sb_det;
    logic [MW-1:0]          w_det_negv;
    logic [W-1:0]           r_sb_det [W+1];
    logic [W:0]             r_sb_sing;

    logic [W-1:0]           n_t [NUM_ENTRIES];
    logic [W-1:0]           r_out_t [NUM_ENTRIES];
    logic [W-1:0]           r_out_det;
    logic                   r_out_sing;

    // Configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dim <= DIM_RESET;
        end else if (i_cfg_wr_en) begin
            r_dim <= i_cfg_wr_data;
        end
    end

    // Stage enables: a stage moves when it is empty or its successor moves.
    always_comb begin
        w_en[NS] = o_out.ready;
        for (int k = NS - 1; k >= 0; k--) begin
            w_en[k] = !r_vld[k] || w_en[k+1];
        end
    end

    assign i_in.ready = w_en[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_en[0]) begin
                r_vld[0] <= i_in.valid;
            end
            for (int k = 1; k < NS; k++) begin
                if (w_en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // The tag rides alongside the item through every stage.
    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r_tag[0] <= i_in.point_tag;
        end
        for (int k = 1; k < NS; k++) begin
            if (w_en[k]) begin
                r_tag[k] <= r_tag[k-1];
            end
        end
    end

    assign w_a[0] = i_in.a00;
    assign w_a[1] = i_in.a01;
    assign w_a[2] = i_in.a02;
    assign w_a[3] = i_in.a10;
    assign w_a[4] = i_in.a11;
    assign w_a[5] = i_in.a12;
    assign w_a[6] = i_in.a20;
    assign w_a[7] = i_in.a21;
    assign w_a[8] = i_in.a22;

    jdit_cofactor #(
        .W (W)
    ) u_cofactor (
        .i_clk  (i_clk),
        .i_en   (w_en[1:0]),
        .i_dim  (r_dim),
        .i_a    (w_a),
        .o_dim  (w_cf_dim),
        .o_a0   (w_cf_a0),
        .o_cof3 (w_cf_cof3),
        .o_cof  (w_cf_cof)
    );

    jdit_det #(
        .W (W),
        .F (F)
    ) u_det (
        .i_clk      (i_clk),
        .i_en       (w_en[5:2]),
        .i_dim      (w_cf_dim),
        .i_a0       (w_cf_a0),
        .i_cof3     (w_cf_cof3),
        .i_cof      (w_cf_cof),
        .o_den      (w_den),
        .o_det_shr  (w_det_shr),
        .o_det_neg  (w_det_neg),
        .o_singular (w_sing),
        .o_num      (w_num),
        .o_num_neg  (w_num_neg)
    );

    jdit_div #(
        .W  (W),
        .NW (NW),
        .MW (MW)
    ) u_div (
        .i_clk     (i_clk),
        .i_en      (w_en[DIV0+W:DIV0]),
        .i_num     (w_num),
        .i_num_neg (w_num_neg),
        .i_den     (w_den),
        .o_quo     (w_quo),
        .o_ovf     (w_ovf),
        .o_neg     (w_neg)
    );

    // Saturate the scaled determinant as it enters the divider section.
    always_comb begin
        w_det_negv = MW'(0) - w_det_shr;
        if (w_det_neg) begin
            n_sb_det = (w_det_shr > DET_LIM) ? SAT_MIN : w_det_negv[W-1:0];
        end else begin
            n_sb_det = (w_det_shr >= DET_LIM) ? SAT_MAX : w_det_shr[W-1:0];
        end
    end

    // Determinant and singular flag wait beside the divider.
    always_ff @(posedge i_clk) begin
        if (w_en[DIV0]) begin
            r_sb_det[0]  <= n_sb_det;
            r_sb_sing[0] <= w_sing;
        end
        for (int s = 1; s <= W; s++) begin
            if (w_en[DIV0+s]) begin
                r_sb_det[s]  <= r_sb_det[s-1];
                r_sb_sing[s] <= r_sb_sing[s-1];
            end
        end
    end

    // Output stage: apply sign, saturate, and drop everything for a singular matrix.
    always_comb begin
        for (int l = 0; l < NUM_ENTRIES; l++) begin
            if (r_sb_sing[W]) begin
                n_t[l] = '0;
            end else if (w_neg[l]) begin
                n_t[l] = (w_ovf[l] || (w_quo[l] > Q_LIM)) ? SAT_MIN : (W'(0) - w_quo[l]);
            end else begin
                n_t[l] = (w_ovf[l] || (w_quo[l] >= Q_LIM)) ? SAT_MAX : w_quo[l];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[NS-1]) begin
            r_out_t    <= n_t;
            r_out_det  <= r_sb_det[W];
            r_out_sing <= r_sb_sing[W];
        end
    end

    assign o_out.valid       = r_vld[NS-1];
    assign o_out.tag_out     = r_tag[NS-1];
    assign o_out.determinant = r_out_det;
    assign o_out.t00         = r_out_t[0];
    assign o_out.t01         = r_out_t[1];
    assign o_out.t02         = r_out_t[2];
    assign o_out.t10         = r_out_t[3];
    assign o_out.t11         = r_out_t[4];
    assign o_out.t12         = r_out_t[5];
    assign o_out.t20         = r_out_t[6];
    assign o_out.t21         = r_out_t[7];
    assign o_out.t22         = r_out_t[8];
    assign o_out.singular    = r_out_sing;

`ifndef ASSERT_OFF
    // A singular result carries a zero determinant and a zero inverse.
    ap_singular_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.singular) |->
            (o_out.determinant == '0) && (o_out.t00 == '0) && (o_out.t01 == '0) &&
            (o_out.t02 == '0) && (o_out.t10 == '0) && (o_out.t11 == '0) &&
            (o_out.t12 == '0) && (o_out.t20 == '0) && (o_out.t21 == '0) &&
            (o_out.t22 == '0))
        else $error("singular result with nonzero payload");

    // Input back-pressure only when every stage holds an item.
    ap_full_before_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in.ready |-> (&r_vld))
        else $error("input stalled while pipeline has a bubble");
`endif

endmodule

// ----- dv/jacobian_det_inverse_transpose_unit_checker.sv -----
// Checker: predicts each result item from the accepted matrix items and compares.
module jacobian_det_inverse_transpose_unit_checker #(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_wr_en,
    input  logic [jdit_pkg::DIM_W-1:0] i_cfg_wr_data,
    jdit_in_if                         i_in,
    jdit_out_if                        i_out,
    output int                         o_fail_count,
    output int                         o_pending
);
    import jdit_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    typedef logic signed [DATA_WIDTH-1:0] t_word;
    typedef logic signed [255:0]          t_wide;

    typedef struct packed {
        logic [TAG_W-1:0] tag;
        t_word            det;
        t_word [8:0]      tinv;
        logic             singular;
    } t_jac_result;

    t_jac_result      expected_results[$];
    logic [DIM_W-1:0] active_dim;
    int               fail_count;

    assign o_fail_count = fail_count;
    assign o_pending    = expected_results.size();

    function automatic t_word saturate(t_wide v);
        t_wide hi, lo;
        hi = (t_wide'(1) <<< (DATA_WIDTH - 1)) - 1;
        lo = -(t_wide'(1) <<< (DATA_WIDTH - 1));
        if (v > hi) return t_word'(hi);
        if (v < lo) return t_word'(lo);
        return t_word'(v);
    endfunction

    // Exact products, then truncate toward zero and saturate.
    function automatic t_jac_result predict_inverse_transpose(
        logic [DIM_W-1:0] dim, logic [TAG_W-1:0] tag, t_word ent [9]);
        t_jac_result r;
        t_wide       m [3][3];
        t_wide       cof [3][3];
        t_wide       det, mag, q;
        int          n;
        n = (dim == DIM_TWO) ? 2 : (dim == DIM_THREE) ? 3 : 1;
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++) begin
                m[i][j]   = t_wide'(ent[i*3+j]);
                cof[i][j] = 0;
            end
        if (n == 1) begin
            cof[0][0] = 1;
            det = m[0][0];
        end else if (n == 2) begin
            cof[0][0] = m[1][1];
            cof[1][1] = m[0][0];
            cof[0][1] = -m[1][0];
            cof[1][0] = -m[0][1];
            det = m[0][0] * m[1][1] - m[0][1] * m[1][0];
        end else begin
            for (int i = 0; i < 3; i++)
                for (int j = 0; j < 3; j++)
                    cof[i][j] = m[(i+1)%3][(j+1)%3] * m[(i+2)%3][(j+2)%3]
                              - m[(i+1)%3][(j+2)%3] * m[(i+2)%3][(j+1)%3];
            det = m[0][0]*cof[0][0] + m[0][1]*cof[0][1] + m[0][2]*cof[0][2];
        end
        r.tag = tag;
        mag = (det < 0) ? -det : det;
        mag = mag >>> ((n - 1) * FRAC_BITS);
        r.det = saturate((det < 0) ? -mag : mag);
        r.singular = (det == 0);
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++) begin
                r.tinv[i*3+j] = '0;
                if (i < n && j < n && det != 0) begin
                    // SV signed division truncates toward zero.
                    q = (cof[i][j] <<< (2 * FRAC_BITS)) / det;
                    r.tinv[i*3+j] = saturate(q);
                end
            end
        return r;
    endfunction

    task automatic compare_field(string name, t_word exp_v, t_word act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected %0d, got %0d", name, exp_v, act_v);
            fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_word       ent [9];
        t_word       act [9];
        t_jac_result exp_r;
        if (!i_rst_n) begin
            active_dim <= DIM_RESET;
            fail_count <= 0;
            expected_results.delete();
        end else begin
            if (i_cfg_wr_en) active_dim <= i_cfg_wr_data;
            if (i_in.valid && i_in.ready) begin
                ent = '{i_in.a00, i_in.a01, i_in.a02, i_in.a10, i_in.a11, i_in.a12,
                        i_in.a20, i_in.a21, i_in.a22};
                expected_results.push_back(
                    predict_inverse_transpose(active_dim, i_in.point_tag, ent));
            end
            if (i_out.valid && i_out.ready) begin
                if (expected_results.size() == 0) begin
                    $error("result item with no matrix item waiting");
                    fail_count++;
                end else begin
                    exp_r = expected_results.pop_front();
                    act = '{i_out.t00, i_out.t01, i_out.t02, i_out.t10, i_out.t11,
                            i_out.t12, i_out.t20, i_out.t21, i_out.t22};
                    compare_field("tag_out", t_word'(exp_r.tag), t_word'(i_out.tag_out));
                    compare_field("determinant", exp_r.det, i_out.determinant);
                    compare_field("singular", t_word'(exp_r.singular),
                                  t_word'(i_out.singular));
                    for (int k = 0; k < 9; k++)
                        compare_field($sformatf("t%0d%0d", k / 3, k % 3),
                                      exp_r.tinv[k], act[k]);
                end
            end
        end
    end
endmodule

// ----- dv/jacobian_det_inverse_transpose_unit_test.sv -----
// Testbench top: drives matrix items and size settings, gives the verdict.
module jacobian_det_inverse_transpose_unit_test;
    import jdit_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DATA_WIDTH = 32;
    localparam int FRAC_BITS  = 16;
    localparam int LATENCY    = DATA_WIDTH + 8;
    // Cycles with no accepted item before giving up; covers pipeline fill plus stalls.
    localparam int IDLE_LIMIT = 2000;

    typedef logic signed [DATA_WIDTH-1:0] t_word;

    logic             i_clk;
    logic             i_rst_n;
    logic             cfg_wr_en;
    logic [DIM_W-1:0] cfg_wr_data;
    int               fail_count;
    int               pending;
    int               idle_cycles;
    bit               quiet_mode;   // long stretch with no idling on the matrix side
    bit               sink_quiet;

    jdit_in_if  #(.DATA_WIDTH(DATA_WIDTH)) mat_ch ();
    jdit_out_if #(.DATA_WIDTH(DATA_WIDTH)) res_ch ();

    jacobian_det_inverse_transpose_unit #(
        .DATA_WIDTH(DATA_WIDTH), .FRAC_BITS(FRAC_BITS)
    ) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_wr_en(cfg_wr_en), .i_cfg_wr_data(cfg_wr_data),
        .i_in(mat_ch.sink), .o_out(res_ch.source)
    );

    jacobian_det_inverse_transpose_unit_checker #(
        .DATA_WIDTH(DATA_WIDTH), .FRAC_BITS(FRAC_BITS)
    ) checker_inst (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_wr_en(cfg_wr_en), .i_cfg_wr_data(cfg_wr_data),
        .i_in(mat_ch), .i_out(res_ch),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Result side: stall at random about 9 percent of the time unless in the quiet stretch.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
        end else begin
            res_ch.ready <= sink_quiet || ($urandom_range(99) >= 9);
        end
    end

    // Watchdog: count cycles with no accepted item on either channel.
    always @(posedge i_clk) begin
        if (!i_rst_n || (mat_ch.valid && mat_ch.ready) || (res_ch.valid && res_ch.ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("jacobian_det_inverse_transpose_unit_test: FAIL");
                $finish;
            end
        end
    end

    // Pick an entry: mostly modest Q16.16 values, sometimes extremes or full range.
    function automatic t_word pick_entry();
        case ($urandom_range(9))
            0:       return t_word'(32'h8000_0000);
            1:       return t_word'(32'h7FFF_FFFF);
            2:       return '0;
            3:       return t_word'($urandom);
            4:       return t_word'(32'sd65536);
            default: return t_word'($signed($urandom_range(32'h40000)) - 32'sh20000);
        endcase
    endfunction

    // Hold the item until accepted; idle at random before it.
    task automatic send_matrix(logic [TAG_W-1:0] tag, t_word ent [9]);
        while (!quiet_mode && $urandom_range(99) < 9) begin
            mat_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        mat_ch.valid     <= 1'b1;
        mat_ch.point_tag <= tag;
        {mat_ch.a00, mat_ch.a01, mat_ch.a02} <= {ent[0], ent[1], ent[2]};
        {mat_ch.a10, mat_ch.a11, mat_ch.a12} <= {ent[3], ent[4], ent[5]};
        {mat_ch.a20, mat_ch.a21, mat_ch.a22} <= {ent[6], ent[7], ent[8]};
        @(posedge i_clk);
        while (!mat_ch.ready) @(posedge i_clk);
    endtask

    task automatic send_random(int count, bit singular_bias);
        t_word ent [9];
        for (int k = 0; k < count; k++) begin
            foreach (ent[e]) ent[e] = pick_entry();
            // Make rows dependent now and then to hit singular matrices.
            if (singular_bias && $urandom_range(3) == 0) begin
                ent[3] = ent[0]; ent[4] = ent[1]; ent[5] = ent[2];
            end
            send_matrix(TAG_W'($urandom), ent);
        end
    endtask

    // Drain every expected result, then pass the pipeline latency before a write.
    task automatic drain_outputs();
        mat_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (LATENCY) @(posedge i_clk);
    endtask

    task automatic set_dimension(logic [DIM_W-1:0] dim);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= dim;
        @(posedge i_clk);
        cfg_wr_en   <= 1'b0;
        @(posedge i_clk);
    endtask

    initial begin
        t_word ent [9];
        logic [DIM_W-1:0] dims [4];
        i_rst_n      = 1'b0;
        cfg_wr_en    = 1'b0;
        cfg_wr_data  = '0;
        mat_ch.valid = 1'b0;
        mat_ch.point_tag = '0;
        {mat_ch.a00, mat_ch.a01, mat_ch.a02} = '0;
        {mat_ch.a10, mat_ch.a11, mat_ch.a12} = '0;
        {mat_ch.a20, mat_ch.a21, mat_ch.a22} = '0;
        quiet_mode = 1'b0;
        sink_quiet = 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed at reset size 3: identity, zero (singular), extremes, tiny det.
        ent = '{32'sd65536, 0, 0, 0, 32'sd65536, 0, 0, 0, 32'sd65536};
        send_matrix(8'd0, ent);
        ent = '{default: '0};
        send_matrix(8'hFF, ent);
        ent = '{default: t_word'(32'h7FFF_FFFF)};
        send_matrix(8'hA5, ent);
        ent = '{default: t_word'(32'h8000_0000)};
        send_matrix(8'h5A, ent);
        ent = '{32'h8000_0000, 32'h7FFF_FFFF, 0, 32'h7FFF_FFFF, 32'h8000_0000, 0,
                0, 0, 32'h7FFF_FFFF};
        send_matrix(8'h01, ent);
        ent = '{32'sd1, 0, 0, 0, 32'sd1, 0, 0, 0, 32'sd1};   // det truncates to zero
        send_matrix(8'h02, ent);
        ent = '{32'sd65536, 32'sd131072, 32'sd196608, 32'sd131072, 32'sd262144,
                32'sd393216, 32'sd7, -32'sd9, 32'sd3};        // dependent rows
        send_matrix(8'h03, ent);

        // Hold off until every result is back.
        drain_outputs();

        // Sizes 2, 1 and 3 directed, including dimension code zero.
        dims = '{DIM_TWO, DIM_ONE, DIM_ZERO, DIM_THREE};
        foreach (dims[d]) begin
            set_dimension(dims[d]);
            ent = '{32'sd1, -32'sd1, 32'sd5, 32'sd2, 32'sd3, 32'sd5, 32'sd5, 32'sd5, 32'sd5};
            send_matrix(8'h10, ent);
            ent = '{32'h8000_0000, 32'h7FFF_FFFF, -32'sd1, 32'h7FFF_FFFF, 32'h8000_0000,
                    -32'sd1, -32'sd1, -32'sd1, -32'sd1};
            send_matrix(8'h11, ent);
            ent = '{32'sd0, 32'sd3, 32'sd1, 32'sd0, 32'sd4, 32'sd1, 32'sd9, 32'sd9, 32'sd9};
            send_matrix(8'h12, ent);
            drain_outputs();
        end

        // Random phases over every size; one stretch with no idling at all.
        dims = '{DIM_THREE, DIM_ONE, DIM_TWO, DIM_THREE};
        foreach (dims[d]) begin
            set_dimension(dims[d]);
            quiet_mode = (d == 2);
            sink_quiet = (d == 2);
            send_random(180, 1'b1);
            drain_outputs();
        end
        quiet_mode = 1'b0;
        sink_quiet = 1'b0;

        if (fail_count == 0) begin
            $display("jacobian_det_inverse_transpose_unit_test: PASS");
        end else begin
            $display("jacobian_det_inverse_transpose_unit_test: FAIL");
        end
        $finish;
    end
endmodule

// ----- filelist.f -----
design/jdit_pkg.sv
design/jdit_if.sv
design/jdit_cofactor.sv
design/jdit_det.sv
design/jdit_div.sv
design/jacobian_det_inverse_transpose_unit.sv
dv/jacobian_det_inverse_transpose_unit_checker.sv
dv/jacobian_det_inverse_transpose_unit_test.sv
